### src/assert_macros.svh
// Assertion macros used by the port checker of this block.
// Each macro builds one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("port check failed");

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden port condition seen");

`endif

### src/msb_pkg.sv
// Shared types and constants of the merge sort batch block.
// Used by the sequencer and the top level; depends on nothing.
`default_nettype none

package msb_pkg;

	localparam int unsigned PORT_BITS = 32;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_SETUP = 4'b0010,
		ST_MERGE = 4'b0100,
		ST_OUT   = 4'b1000
	} msb_state_t;

	typedef struct packed {
		logic wr_store;
		logic wr_buf;
		logic src_buf;
	} msb_memctl_t;

endpackage

`default_nettype wire

### src/msb_ram.sv
// Single-write, dual-read synchronous memory with registered read data.
// Holds one sort buffer; depends on nothing.
`default_nettype none

module msb_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

### src/msb_seq.sv
// Sequencer of the merge sort: loads the batch, runs the bottom-up merge passes
// between the two buffers and reads the sorted result out. Depends on msb_pkg.
`default_nettype none

module msb_seq #(
	parameter int unsigned MAX_ITEMS  = 64,
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned AW         = $clog2(MAX_ITEMS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  last,
	input  wire logic [VALUE_BITS-1:0] in_value,
	input  wire logic [VALUE_BITS-1:0] head_a,
	input  wire logic [VALUE_BITS-1:0] head_b,
	output logic                       busy,
	output msb_pkg::msb_memctl_t       ctl,
	output logic      [AW-1:0]         wr_addr,
	output logic      [VALUE_BITS-1:0] wr_data,
	output logic      [AW-1:0]         rd_addr_a,
	output logic      [AW-1:0]         rd_addr_b,
	output logic                       res_valid,
	output logic                       res_last,
	output logic                       res_ovf
);

	import msb_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam int unsigned SW = CW + 2;

	msb_state_t    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          ovf_q, ovf_d;
	logic [CW-1:0] w_q, w_d;
	logic [CW-1:0] k_q, k_d;
	logic [CW-1:0] a_q, a_d;
	logic [CW-1:0] b_q, b_d;
	logic [CW-1:0] mid_q, mid_d;
	logic [CW-1:0] hi_q, hi_d;
	logic          src_q, src_d;

	logic          accept;
	logic          full;
	logic [CW-1:0] n_close;
	logic          a_ok;
	logic          b_ok;
	logic          take_a;
	logic [CW-1:0] k_inc;
	logic [CW-1:0] out_inc;

	function automatic logic [CW-1:0] clamp_n(input logic [SW-1:0] x, input logic [CW-1:0] n);
		logic [CW-1:0] r;
		if (x >= SW'(n)) begin
			r = n;
		end else begin
			r = x[CW-1:0];
		end
		return r;
	endfunction

	assign busy    = (state_q != ST_LOAD);
	assign accept  = start && !busy;
	assign full    = (cnt_q == CW'(MAX_ITEMS));
	assign n_close = full ? cnt_q : cnt_q + CW'(1);
	assign a_ok    = (a_q < mid_q);
	assign b_ok    = (b_q < hi_q);
	assign take_a  = a_ok && (!b_ok || (head_a <= head_b));
	assign k_inc   = k_q + CW'(1);
	assign out_inc = a_q + CW'(1);

	assign res_valid = (state_q == ST_OUT);
	assign res_last  = (state_q == ST_OUT) && (out_inc == cnt_q);
	assign res_ovf   = ovf_q;
	assign rd_addr_a = a_d[AW-1:0];
	assign rd_addr_b = b_d[AW-1:0];

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		w_d     = w_q;
		k_d     = k_q;
		a_d     = a_q;
		b_d     = b_q;
		mid_d   = mid_q;
		hi_d    = hi_q;
		src_d   = src_q;
		ctl     = '0;
		ctl.src_buf = src_q;
		wr_addr = cnt_q[AW-1:0];
		wr_data = in_value;
		case (state_q)
			ST_LOAD: begin
				if (accept) begin
					if (full) begin
						ovf_d = 1'b1;
					end else begin
						ctl.wr_store = 1'b1;
						cnt_d = cnt_q + CW'(1);
					end
					if (last) begin
						cnt_d   = n_close;
						w_d     = CW'(1);
						src_d   = 1'b0;
						state_d = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				k_d = '0;
				a_d = '0;
				if (w_q >= cnt_q) begin
					state_d = ST_OUT;
				end else begin
					mid_d   = w_q;
					hi_d    = clamp_n(SW'(w_q) << 1, cnt_q);
					b_d     = w_q;
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				wr_addr      = k_q[AW-1:0];
				wr_data      = take_a ? head_a : head_b;
				ctl.wr_store = src_q;
				ctl.wr_buf   = !src_q;
				k_d          = k_inc;
				if (k_inc == hi_q) begin
					if (hi_q == cnt_q) begin
						w_d     = clamp_n(SW'(w_q) << 1, cnt_q);
						src_d   = !src_q;
						state_d = ST_SETUP;
					end else begin
						mid_d = clamp_n(SW'(hi_q) + SW'(w_q), cnt_q);
						hi_d  = clamp_n(SW'(hi_q) + (SW'(w_q) << 1), cnt_q);
						a_d   = hi_q;
						b_d   = clamp_n(SW'(hi_q) + SW'(w_q), cnt_q);
					end
				end else begin
					a_d = a_q + CW'(take_a);
					b_d = b_q + CW'(!take_a);
				end
			end
			ST_OUT: begin
				a_d = out_inc;
				if (res_last) begin
					cnt_d   = '0;
					ovf_d   = 1'b0;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			w_q     <= '0;
			k_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			src_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
			w_q     <= w_d;
			k_q     <= k_d;
			a_q     <= a_d;
			b_q     <= b_d;
			mid_q   <= mid_d;
			hi_q    <= hi_d;
			src_q   <= src_d;
		end
	end

endmodule

`default_nettype wire

### src/merge_sort_batch.sv
// Batch merge sorter: loads one value per transfer, start accepted when busy is low.
// After the transfer marked last, the n held values are sorted in P = ceil(log2 n) passes,
// each of one setup step and then one merged element per cycle out of the dual-read source
// buffer; once the passes are done, n results come on consecutive cycles.
// Reset clears the count, the overflow flag and the sequencer; the buffers are not cleared.
`default_nettype none

module merge_sort_batch #(
	parameter int unsigned MAX_ITEMS  = 64,
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] value,
	input  wire logic        last,
	output logic             result_valid,
	output logic      [31:0] sorted_value,
	output logic             last_res,
	output logic             overflow
);

	import msb_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ITEMS);

	msb_memctl_t           ctl;
	logic [AW-1:0]         wr_addr;
	logic [VALUE_BITS-1:0] wr_data;
	logic [AW-1:0]         rd_addr_a;
	logic [AW-1:0]         rd_addr_b;
	logic [VALUE_BITS-1:0] store_a;
	logic [VALUE_BITS-1:0] store_b;
	logic [VALUE_BITS-1:0] buf_a;
	logic [VALUE_BITS-1:0] buf_b;
	logic [VALUE_BITS-1:0] head_a;
	logic [VALUE_BITS-1:0] head_b;
	logic [VALUE_BITS-1:0] in_value;

	assign head_a = ctl.src_buf ? buf_a : store_a;
	assign head_b = ctl.src_buf ? buf_b : store_b;

	if (VALUE_BITS >= PORT_BITS) begin : g_wide
		assign in_value     = VALUE_BITS'(value);
		assign sorted_value = head_a[PORT_BITS-1:0];
	end else begin : g_narrow
		assign in_value     = value[VALUE_BITS-1:0];
		assign sorted_value = PORT_BITS'(head_a);
	end

	msb_seq #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last      (last),
		.in_value  (in_value),
		.head_a    (head_a),
		.head_b    (head_b),
		.busy      (busy),
		.ctl       (ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.res_valid (result_valid),
		.res_last  (last_res),
		.res_ovf   (overflow)
	);

	msb_ram #(
		.DEPTH (MAX_ITEMS),
		.WIDTH (VALUE_BITS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.we      (ctl.wr_store),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (store_a),
		.rdata_b (store_b)
	);

	msb_ram #(
		.DEPTH (MAX_ITEMS),
		.WIDTH (VALUE_BITS),
		.AW    (AW)
	) u_buf (
		.clk     (clk),
		.we      (ctl.wr_buf),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (buf_a),
		.rdata_b (buf_b)
	);

endmodule

`default_nettype wire

### src/msb_port_chk.sv
// Port-level checks of the merge sort batch block and the bind that attaches them.
// Depends on assert_macros.svh and the ports of merge_sort_batch.
`default_nettype none
`include "assert_macros.svh"

module msb_port_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic last,
	input wire logic result_valid,
	input wire logic last_res
);

	// Results are only shown while the block is busy with a batch.
	`ASSERT_PROP(a_res_while_busy, clk, arst_n, result_valid |-> busy)

	`ASSERT_NEVER(a_last_without_valid, clk, arst_n, last_res && !result_valid)

	// The results of one batch come out on consecutive cycles.
	`ASSERT_PROP(a_res_contiguous, clk, arst_n, (result_valid && !last_res) |=> result_valid)

	`ASSERT_PROP(a_batch_ends, clk, arst_n, (result_valid && last_res) |=> !result_valid)

	// A closing transfer always starts the sort.
	`ASSERT_PROP(a_close_starts_sort, clk, arst_n, (start && !busy && last) |=> busy)

endmodule

bind merge_sort_batch msb_port_chk u_port_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last         (last),
	.result_valid (result_valid),
	.last_res     (last_res)
);

`default_nettype wire

### dv/merge_sort_batch_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for merge_sort_batch: directed batches, then random batches.
// Each transfer feeds an in-bench stable sort predictor; depends on the RTL and msb_pkg.

module merge_sort_batch_tb;

	localparam int CAPACITY     = 64;
	localparam int RANDOM_ITEMS = 350;
	localparam int CALM_ITEMS   = 60;
	localparam int TAIL_CYCLES  = 500;
	localparam int DRAIN_LIMIT  = 20000;

	typedef struct {
		logic [31:0] val;
		logic        lst;
		logic        ovf;
	} sort_res_t;

	typedef struct {
		logic [31:0] v;
		logic        l;
		bit          typed;
		logic [31:0] ev;
		logic        el;
		logic        eo;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] value = '0;
	logic        last = 1'b0;
	logic        busy;
	logic        result_valid;
	logic [31:0] sorted_value;
	logic        last_res;
	logic        overflow;

	logic [31:0] held_vals [$];
	bit          held_dropped = 1'b0;
	sort_res_t   sorted_exp_q [$];
	int          fail_cnt = 0;
	int          random_sent = 0;

	stim_row_t directed_tbl [16] = '{
		'{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0007, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0003, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0003, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0003, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0002, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0009, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0008, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0007, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0}
	};

	merge_sort_batch dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.last         (last),
		.result_valid (result_valid),
		.sorted_value (sorted_value),
		.last_res     (last_res),
		.overflow     (overflow)
	);

	always #10 clk = ~clk;

	// Holds the element or marks it dropped; on a closing transfer sorts the batch stably.
	function automatic void absorb_transfer(input logic [31:0] v, input logic l, input bit emit);
		logic [31:0] arr [CAPACITY];
		logic [31:0] key;
		sort_res_t   r;
		int          n;
		int          i;
		int          j;
		if (held_vals.size() < CAPACITY)
			held_vals.push_back(v);
		else
			held_dropped = 1'b1;
		if (!l)
			return;
		n = held_vals.size();
		for (i = 0; i < n; i++)
			arr[i] = held_vals[i];
		for (i = 1; i < n; i++) begin
			key = arr[i];
			j = i;
			while (j > 0 && arr[j - 1] > key) begin
				arr[j] = arr[j - 1];
				j--;
			end
			arr[j] = key;
		end
		if (emit) begin
			for (i = 0; i < n; i++) begin
				r.val = arr[i];
				r.lst = (i == n - 1);
				r.ovf = held_dropped;
				sorted_exp_q.push_back(r);
			end
		end
		held_vals.delete();
		held_dropped = 1'b0;
	endfunction

	task automatic send_item(input logic [31:0] v, input logic l, input bit emit);
		start <= 1'b1;
		value <= v;
		last <= l;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		absorb_transfer(v, l, emit);
	endtask

	task automatic idle_burst(input int cycles);
		start <= 1'b0;
		value <= $urandom;
		last <= 1'($urandom_range(0, 1));
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sorted_exp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_batch(input int size, input int mode);
		logic [31:0] v;
		int          k;
		for (k = 0; k < size; k++) begin
			case (mode)
				0: v = $urandom;
				1: v = $urandom_range(0, 3);
				default: begin
					case ($urandom_range(0, 4))
						0: v = 32'h0000_0000;
						1: v = 32'hFFFF_FFFF;
						2: v = 32'h8000_0000;
						3: v = 32'h7FFF_FFFF;
						default: v = $urandom;
					endcase
				end
			endcase
			if (random_sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
				idle_burst($urandom_range(1, 5));
			send_item(v, k == size - 1, 1'b1);
			random_sent++;
		end
	endtask

	always @(negedge clk) begin
		sort_res_t exp_r;
		if (arst_n && result_valid) begin
			if (sorted_exp_q.size() == 0) begin
				$error("unexpected result: sorted_value %h", sorted_value);
				fail_cnt++;
			end else begin
				exp_r = sorted_exp_q.pop_front();
				if (sorted_value !== exp_r.val) begin
					$error("sorted_value: expected %h, got %h", exp_r.val, sorted_value);
					fail_cnt++;
				end
				if (last_res !== exp_r.lst) begin
					$error("last_res: expected %b, got %b", exp_r.lst, last_res);
					fail_cnt++;
				end
				if (overflow !== exp_r.ovf) begin
					$error("overflow: expected %b, got %b", exp_r.ovf, overflow);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		sort_res_t r;
		int        sz;
		int        guard;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_tbl[i]) begin
			send_item(directed_tbl[i].v, directed_tbl[i].l, !directed_tbl[i].typed);
			if (directed_tbl[i].typed) begin
				r.val = directed_tbl[i].ev;
				r.lst = directed_tbl[i].el;
				r.ovf = directed_tbl[i].eo;
				sorted_exp_q.push_back(r);
			end
		end
		drain_results();
		// A batch that exactly fills the store, then one whose last two transfers are dropped.
		random_batch(CAPACITY, 0);
		random_batch(CAPACITY + 2, $urandom_range(0, 2));
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0: sz = $urandom_range(CAPACITY + 1, CAPACITY + 8);
				1, 2, 3: sz = $urandom_range(13, CAPACITY);
				default: sz = $urandom_range(1, 12);
			endcase
			random_batch(sz, $urandom_range(0, 2));
			if (random_sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 7) == 0)
				drain_results();
		end
		start <= 1'b0;
		for (guard = 0; guard < DRAIN_LIMIT && sorted_exp_q.size() != 0; guard++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sorted_exp_q.size() != 0) begin
			$error("%0d expected results never arrived", sorted_exp_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
